// File: rtl/hee_pkg.sv
package hee_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Replacement character U+FFFD as UTF-8, left aligned in a job.
  localparam logic [47:0] FFFD_DATA = 48'hEFBFBD_000000;

  typedef enum logic [1:0] {
    JOB_RAW,
    JOB_DEC,
    JOB_END
  } job_kind_e;

  // RAW: cnt bytes, first byte in data[47:40]. DEC: value in data[20:0].
  typedef struct packed {
    job_kind_e   kind;
    logic [2:0]  cnt;
    logic [47:0] data;
    logic        last;
  } job_t;

endpackage

// File: rtl/hee_in_if.sv
interface hee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/hee_out_if.sv
interface hee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output string_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input string_end, output ready);
endinterface

// File: rtl/hee_front.sv
module hee_front import hee_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hee_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output job_t   job_o
);

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_2    = 3'd2;
  localparam logic [2:0] SEQ_3    = 3'd3;
  localparam logic [2:0] SEQ_4    = 3'd4;

  logic        es_q, es_d;
  logic [2:0]  seq_q, seq_d;
  logic [1:0]  gat_q, gat_d;
  logic [23:0] held_q, held_d;
  logic [1:0]  swl_q, swl_d;

  logic        accept;
  logic        jv;
  job_t        job;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && jv;
  assign job_o      = job;

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic [2:0]  rem;

    b   = in_i.in_byte;
    lst = in_i.in_last;
    v2  = {held_q[4:0], b[5:0]};
    v3  = {held_q[11:8], held_q[5:0], b[5:0]};
    v4  = {held_q[18:16], held_q[13:8], held_q[5:0], b[5:0]};
    rem = seq_q - 3'd1 - {1'b0, gat_q};

    es_d     = es_q;
    seq_d    = seq_q;
    gat_d    = gat_q;
    held_d   = held_q;
    swl_d    = swl_q;
    jv       = 1'b0;
    job      = '0;
    job.kind = JOB_RAW;
    job.last = lst;

    if (swl_q != 2'd0) begin
      swl_d = swl_q - 2'd1;
    end else if (seq_q != SEQ_NONE) begin
      if (b[7:6] != 2'b10) begin
        jv       = 1'b1;
        job.cnt  = 3'd3;
        job.data = FFFD_DATA;
        es_d     = 1'b1;
        swl_d    = rem[1:0];
        seq_d    = SEQ_NONE;
        gat_d    = 2'd0;
        held_d   = '0;
      end else if ({1'b0, gat_q} + 3'd1 == seq_q) begin
        jv = 1'b1;
        case (seq_q)
          SEQ_2: begin
            if (v2 >= 11'd160 && v2 < 11'd256) begin
              job.kind = JOB_DEC;
              job.data = {37'h0, v2};
              es_d     = 1'b1;
            end else begin
              job.cnt  = 3'd2;
              job.data = {held_q[7:0], b, 32'h0};
            end
          end
          SEQ_3: begin
            if (v3 >= 16'hD800 && v3 <= 16'hDFFF) begin
              job.cnt  = 3'd3;
              job.data = FFFD_DATA;
              es_d     = 1'b1;
            end else begin
              job.cnt  = 3'd3;
              job.data = {held_q[15:0], b, 24'h0};
            end
          end
          default: begin
            if (es_q || v4 >= 21'h10000) begin
              job.kind = JOB_DEC;
              job.data = {27'h0, v4};
              es_d     = 1'b1;
            end else begin
              job.cnt  = 3'd4;
              job.data = {held_q, b, 16'h0};
            end
          end
        endcase
        seq_d  = SEQ_NONE;
        gat_d  = 2'd0;
        held_d = '0;
      end else begin
        held_d = {held_q[15:0], b};
        gat_d  = gat_q + 2'd1;
        if (lst) begin
          jv       = 1'b1;
          job.cnt  = 3'd3;
          job.data = FFFD_DATA;
        end
      end
    end else if (!b[7]) begin
      jv = 1'b1;
      case (b)
        CH_LT: begin
          job.cnt  = 3'd4;
          job.data = {"&lt;", 16'h0};
          es_d     = 1'b1;
        end
        CH_GT: begin
          job.cnt  = 3'd4;
          job.data = {"&gt;", 16'h0};
          es_d     = 1'b1;
        end
        CH_QUOT: begin
          job.cnt  = 3'd6;
          job.data = "&quot;";
          es_d     = 1'b1;
        end
        CH_APOS: begin
          job.cnt  = 3'd5;
          job.data = {"&#39;", 8'h0};
          es_d     = 1'b1;
        end
        CH_AMP: begin
          job.cnt  = 3'd5;
          job.data = {"&amp;", 8'h0};
          es_d     = 1'b1;
        end
        default: begin
          job.cnt  = 3'd1;
          job.data = {b, 40'h0};
        end
      endcase
    end else if (b[7:6] == 2'b10) begin
      jv = 1'b1;
      if (es_q) begin
        job.cnt  = 3'd3;
        job.data = FFFD_DATA;
      end else begin
        job.cnt  = 3'd1;
        job.data = {b, 40'h0};
      end
    end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
      if (b[7:5] == 3'b110) begin
        seq_d = SEQ_2;
      end else if (b[7:4] == 4'b1110) begin
        seq_d = SEQ_3;
      end else begin
        seq_d = SEQ_4;
      end
      gat_d  = 2'd1;
      held_d = {16'h0, b};
      if (lst) begin
        jv       = 1'b1;
        job.cnt  = 3'd3;
        job.data = FFFD_DATA;
      end
    end else begin
      jv       = 1'b1;
      job.cnt  = 3'd1;
      job.data = {b, 40'h0};
    end

    if (lst) begin
      es_d   = 1'b0;
      seq_d  = SEQ_NONE;
      gat_d  = 2'd0;
      held_d = '0;
      swl_d  = 2'd0;
      if (!jv) begin
        jv       = 1'b1;
        job.kind = JOB_END;
        job.cnt  = 3'd1;
        job.data = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q   <= 1'b0;
      seq_q  <= SEQ_NONE;
      gat_q  <= 2'd0;
      held_q <= '0;
      swl_q  <= 2'd0;
    end else if (accept) begin
      es_q   <= es_d;
      seq_q  <= seq_d;
      gat_q  <= gat_d;
      held_q <= held_d;
      swl_q  <= swl_d;
    end
  end

endmodule

// File: rtl/hee_fifo.sv
module hee_fifo import hee_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hee_back.sv
module hee_back import hee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  job_t       head_i,
  output logic       pop_o,
  hee_out_if.source  out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RAW  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;

  localparam int unsigned DigMax = 7;
  // floor(v / 10) == (v * Div10Mul) >> Div10Shift for every v below 2**26.
  localparam logic [23:0] Div10Mul   = 24'hCCCCCD;
  localparam int unsigned Div10Shift = 27;

  logic [1:0]  st_q, st_d;
  logic [47:0] sh_q, sh_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        dec_q, dec_d;
  logic        bv_q, bv_d;
  logic        last_q, last_d;
  logic        conv_q, conv_d;
  logic [20:0] val_q, val_d;
  logic [2:0]  ndig_q, ndig_d;
  logic [3:0]  dig_q [DigMax];

  logic        ov_q;
  logic [7:0]  obyte_q;
  logic        obv_q, orl_q, ose_q;

  logic        cand_v, cand_bv, cand_rl, cand_se;
  logic [7:0]  cand_byte;
  logic        take, fetch;
  logic [44:0] prod;
  logic [20:0] quo, quo_x10, diff;
  logic [3:0]  digit;

  assign prod    = {24'h0, val_q} * {21'h0, Div10Mul};
  assign quo     = {3'h0, prod[44:Div10Shift]};
  assign quo_x10 = (quo << 3) + (quo << 1);
  assign diff    = val_q - quo_x10;
  assign digit   = diff[3:0];

  always_comb begin
    cand_v    = 1'b0;
    cand_byte = 8'h00;
    cand_bv   = 1'b1;
    cand_rl   = 1'b0;
    cand_se   = 1'b0;
    case (st_q)
      ST_RAW: begin
        cand_v    = 1'b1;
        cand_byte = sh_q[47:40];
        cand_bv   = bv_q;
        cand_rl   = (cnt_q == 3'd1) && !dec_q;
        cand_se   = (cnt_q == 3'd1) && !dec_q && last_q;
      end
      ST_DIG: begin
        cand_v    = !conv_q;
        cand_byte = CH_ZERO | {4'h0, dig_q[ndig_q - 3'd1]};
      end
      default: cand_v = 1'b0;
    endcase
  end

  assign take  = cand_v && (!ov_q || out_o.ready);
  assign fetch = (st_q == ST_IDLE) ||
                 (take && st_q == ST_RAW && cnt_q == 3'd1 && !dec_q);
  assign pop_o = fetch && valid_i;

  always_comb begin
    st_d   = st_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    dec_d  = dec_q;
    bv_d   = bv_q;
    last_d = last_q;
    val_d  = val_q;
    conv_d = conv_q;
    ndig_d = ndig_q;

    if (conv_q) begin
      val_d  = quo;
      ndig_d = ndig_q + 3'd1;
      conv_d = (quo != '0);
    end

    if (take) begin
      case (st_q)
        ST_RAW: begin
          if (cnt_q != 3'd1) begin
            sh_d  = {sh_q[39:0], 8'h00};
            cnt_d = cnt_q - 3'd1;
          end else if (dec_q) begin
            st_d = ST_DIG;
          end
        end
        ST_DIG: begin
          ndig_d = ndig_q - 3'd1;
          if (ndig_q == 3'd1) begin
            st_d  = ST_RAW;
            sh_d  = {CH_SEMI, 40'h0};
            cnt_d = 3'd1;
            dec_d = 1'b0;
            bv_d  = 1'b1;
          end
        end
        default: st_d = st_q;
      endcase
    end

    if (fetch) begin
      if (valid_i) begin
        st_d   = ST_RAW;
        last_d = head_i.last;
        case (head_i.kind)
          JOB_DEC: begin
            sh_d   = {CH_AMP, CH_HASH, 32'h0};
            cnt_d  = 3'd2;
            dec_d  = 1'b1;
            bv_d   = 1'b1;
            val_d  = head_i.data[20:0];
            conv_d = 1'b1;
            ndig_d = 3'd0;
          end
          JOB_END: begin
            sh_d  = '0;
            cnt_d = 3'd1;
            dec_d = 1'b0;
            bv_d  = 1'b0;
          end
          default: begin
            sh_d  = head_i.data;
            cnt_d = head_i.cnt;
            dec_d = 1'b0;
            bv_d  = 1'b1;
          end
        endcase
      end else begin
        st_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= 3'd0;
      dec_q  <= 1'b0;
      bv_q   <= 1'b1;
      last_q <= 1'b0;
      conv_q <= 1'b0;
      ndig_q <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      dec_q  <= dec_d;
      bv_q   <= bv_d;
      last_q <= last_d;
      conv_q <= conv_d;
      ndig_q <= ndig_d;
      if (!ov_q || out_o.ready) begin
        ov_q <= cand_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    val_q <= val_d;
    if (conv_q) begin
      dig_q[ndig_q] <= digit;
    end
    if (take) begin
      obyte_q <= cand_byte;
      obv_q   <= cand_bv;
      orl_q   <= cand_rl;
      ose_q   <= cand_se;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.byte_valid = obv_q;
  assign out_o.run_last   = orl_q;
  assign out_o.string_end = ose_q;

endmodule

// File: rtl/html_escape_utf8_checked.sv
// A request passes through the job queue and the back end's shift register before it reaches the output register.
// Throughput: one output byte per cycle while the output is ready and no decimal digits are pending.
// Decimal references wait for the divide-by-ten digit loop before their digits are sent.
// A request is accepted in any cycle in which the job queue between front and back has room.
// Reset (asynchronous, active low) empties the queue and returns the decoder to string start.
module html_escape_utf8_checked import hee_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hee_in_if.sink    in_i,
  hee_out_if.source out_o
);

  logic q_push, q_full, q_valid, q_pop;
  job_t q_job, q_head;

  hee_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .job_o  (q_job)
  );

  hee_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  hee_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_end_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.byte_valid) |-> (out_o.string_end && out_o.out_byte == 8'h00))
    else $error("empty result outside a string end");

  a_end_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.string_end) |-> out_o.run_last)
    else $error("string end without run end");

endmodule
